/* hdl/stl_pkg.sv */
// shared types and constants of the sorted timestamp list
package stl_pkg;

	localparam int STAMP_W = 63;
	localparam int POS_W = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 5;
	localparam int LIST_DEPTH_DEF = 16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic insert_en;
		logic remove_en;
		logic [STAMP_W-1:0] stamp;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

/* hdl/sorted_timestamp_list.sv */
// top level of the sorted timestamp list: cell row, fill count and result register
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  opcode, stamp, position
// out      output     out_valid / out_ready status, placed_before_end,
//                                          removed_stamp, entry_count
//
// one word per cycle while the output is not stalled: every cell compares and shifts in the cycle a word is taken,
// the result is registered and shown the next cycle.
// a new word is taken while the result register is empty or being emptied.
// reset clears the fill count and the result valid flag; entries and result data need no reset.
// a stalled output holds the input off, nothing is lost.
module sorted_timestamp_list #(
	parameter int LIST_DEPTH = stl_pkg::LIST_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  logic [stl_pkg::STAMP_W-1:0] stamp,
	input  logic [stl_pkg::POS_W-1:0] position,
	output logic out_valid,
	input  logic out_ready,
	output logic [stl_pkg::STATUS_W-1:0] status,
	output logic placed_before_end,
	output logic [stl_pkg::STAMP_W-1:0] removed_stamp,
	output logic [stl_pkg::COUNT_W-1:0] entry_count
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int PW = (CW > stl_pkg::POS_W) ? CW : stl_pkg::POS_W;
	localparam int NR = (LIST_DEPTH < 16) ? LIST_DEPTH : 16;
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	logic [CW-1:0] count_q;
	logic out_valid_q;
	logic [stl_pkg::STATUS_W-1:0] status_q;
	logic placed_q;
	logic [stl_pkg::STAMP_W-1:0] removed_q;
	logic [stl_pkg::COUNT_W-1:0] count_out_q;

	logic accept;
	logic insert_ok;
	logic remove_ok;
	stl_pkg::cell_cmd_t cmd;
	logic [LIST_DEPTH-1:0] less_vec;
	logic [stl_pkg::STAMP_W-1:0] cell_val [LIST_DEPTH];
	logic [stl_pkg::STAMP_W-1:0] pick;
	logic [CW-1:0] count_next;
	logic [stl_pkg::STATUS_W-1:0] status_next;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign insert_ok = (opcode == stl_pkg::OP_INSERT) && (count_q < DEPTH_C);
	assign remove_ok = (opcode == stl_pkg::OP_REMOVE) && (PW'(position) < PW'(count_q));

	assign cmd.insert_en = accept && insert_ok;
	assign cmd.remove_en = accept && remove_ok;
	assign cmd.stamp = stamp;
	assign cmd.pos = position;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		stl_cell #(
			.IDX(i),
			.CW(CW)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.count(count_q),
			.prev_less((i == 0) ? 1'b0 : less_vec[(i == 0) ? 0 : i - 1]),
			.prev_val(cell_val[(i == 0) ? 0 : i - 1]),
			.next_val(cell_val[(i == LIST_DEPTH - 1) ? i : i + 1]),
			.less(less_vec[i]),
			.val(cell_val[i])
		);
	end

	// removal read, position covers at most sixteen entries
	always_comb begin
		pick = '0;
		for (int k = 0; k < NR; k++) begin
			if (position == stl_pkg::POS_W'(k)) begin
				pick = cell_val[k];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		status_next = stl_pkg::ST_DONE;
		if (opcode == stl_pkg::OP_INSERT) begin
			if (insert_ok) begin
				count_next = count_q + CW'(1);
			end else begin
				status_next = stl_pkg::ST_FULL;
			end
		end else begin
			if (remove_ok) begin
				count_next = count_q - CW'(1);
			end else begin
				status_next = stl_pkg::ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			placed_q <= insert_ok && (|less_vec);
			removed_q <= remove_ok ? pick : '0;
			count_out_q <= stl_pkg::COUNT_W'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign placed_before_end = placed_q;
	assign removed_stamp = removed_q;
	assign entry_count = count_out_q;

endmodule

/* hdl/stl_cell.sv */
// one list entry: compare against the new stamp and shift with its neighbors
module stl_cell #(
	parameter int IDX = 0,
	parameter int CW = 5
) (
	input  logic clk,
	input  stl_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0] count,
	input  logic prev_less,
	input  logic [stl_pkg::STAMP_W-1:0] prev_val,
	input  logic [stl_pkg::STAMP_W-1:0] next_val,
	output logic less,
	output logic [stl_pkg::STAMP_W-1:0] val
);

	localparam int PW = (CW > stl_pkg::POS_W) ? CW : stl_pkg::POS_W;
	localparam logic [PW-1:0] IDX_P = PW'(IDX);
	localparam logic [PW:0] IDX_N = (PW + 1)'(IDX + 1);

	logic [stl_pkg::STAMP_W-1:0] stamp_q;
	logic valid;
	logic at_end;
	logic [PW-1:0] pos_p;
	logic [PW-1:0] count_p;

	assign pos_p = PW'(cmd.pos);
	assign count_p = PW'(count);
	assign valid = IDX_P < count_p;
	assign at_end = IDX_P == count_p;
	assign less = valid && (stamp_q < cmd.stamp);
	assign val = stamp_q;

	always_ff @(posedge clk) begin
		if (cmd.insert_en) begin
			if (prev_less) begin
				stamp_q <= prev_val;
			end else if (less || at_end) begin
				stamp_q <= cmd.stamp;
			end
		end else if (cmd.remove_en) begin
			if ((IDX_P >= pos_p) && (IDX_N < {1'b0, count_p})) begin
				stamp_q <= next_val;
			end
		end
	end

endmodule

/* dv/sorted_timestamp_list_check.sv */
// checker for the sorted timestamp list: predicts every result word and compares it
module sorted_timestamp_list_check #(
	parameter int LIST_DEPTH = stl_pkg::LIST_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic opcode,
	input  logic [stl_pkg::STAMP_W-1:0] stamp,
	input  logic [stl_pkg::POS_W-1:0] position,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [stl_pkg::STATUS_W-1:0] status,
	input  logic placed_before_end,
	input  logic [stl_pkg::STAMP_W-1:0] removed_stamp,
	input  logic [stl_pkg::COUNT_W-1:0] entry_count,
	output int errors,
	output int waiting,
	output int stored,
	output int inserts,
	output int removes,
	output int full_refusals,
	output int range_refusals,
	output int peak_fill
);
	import stl_pkg::*;

	localparam int EXP_DEPTH = 16;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic placed;
		logic [STAMP_W-1:0] removed;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic [STAMP_W-1:0] stamps_q [LIST_DEPTH];
	int held;
	int n_insert, n_remove, n_full, n_range, n_peak;
	int fails;
	list_result_t expected_mem [EXP_DEPTH];
	int wr_idx, rd_idx;
	list_result_t got, want;

	function automatic list_result_t apply_list_op(input logic op,
			input logic [STAMP_W-1:0] st, input logic [POS_W-1:0] pos);
		list_result_t res;
		int slot;
		int i;
		res = '0;
		if (op == OP_INSERT) begin
			n_insert++;
			if (held >= LIST_DEPTH) begin
				res.status = ST_FULL;
				n_full++;
			end else begin
				slot = held;
				// lowest index holding a strictly smaller stamp
				for (i = held - 1; i >= 0; i--)
					if (stamps_q[i] < st)
						slot = i;
				res.placed = (slot < held);
				for (i = held; i > slot; i--)
					stamps_q[i] = stamps_q[i - 1];
				stamps_q[slot] = st;
				held++;
			end
		end else begin
			n_remove++;
			if (pos >= held) begin
				res.status = ST_RANGE;
				n_range++;
			end else begin
				res.removed = stamps_q[pos];
				for (i = pos; i + 1 < held; i++)
					stamps_q[i] = stamps_q[i + 1];
				held--;
			end
		end
		if (held > n_peak)
			n_peak = held;
		res.count = COUNT_W'(held);
		return res;
	endfunction

	task automatic report_miss(input string what, input list_result_t exp_word,
			input list_result_t act_word);
		fails++;
		if (fails <= 10)
			$display("%s: expected status %0d placed %0d removed %h count %0d,",
				what, exp_word.status, exp_word.placed, exp_word.removed,
				exp_word.count,
				"  got status %0d placed %0d removed %h count %0d",
				act_word.status, act_word.placed, act_word.removed, act_word.count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx = 0;
			rd_idx = 0;
			held = 0;
			n_insert = 0;
			n_remove = 0;
			n_full = 0;
			n_range = 0;
			n_peak = 0;
			fails = 0;
			errors <= 0;
			waiting <= 0;
			stored <= 0;
			inserts <= 0;
			removes <= 0;
			full_refusals <= 0;
			range_refusals <= 0;
			peak_fill <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {status, placed_before_end, removed_stamp, entry_count};
				if (wr_idx == rd_idx) begin
					report_miss("result word with nothing expected", '0, got);
				end else begin
					want = expected_mem[rd_idx % EXP_DEPTH];
					rd_idx++;
					if (want.status !== got.status || want.placed !== got.placed ||
							want.removed !== got.removed || want.count !== got.count)
						report_miss("result word mismatch", want, got);
				end
			end
			if (in_valid && in_ready) begin
				expected_mem[wr_idx % EXP_DEPTH] = apply_list_op(opcode, stamp, position);
				wr_idx++;
			end
			errors <= fails;
			waiting <= wr_idx - rd_idx;
			stored <= held;
			inserts <= n_insert;
			removes <= n_remove;
			full_refusals <= n_full;
			range_refusals <= n_range;
			peak_fill <= n_peak;
		end
	end

endmodule

/* dv/sorted_timestamp_list_test.sv */
// testbench top for the sorted timestamp list: stimulus, handshake pacing and verdict
module sorted_timestamp_list_test;
	import stl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS = 125;
	localparam logic [STAMP_W-1:0] STAMP_TOP = '1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic opcode;
	logic [STAMP_W-1:0] stamp;
	logic [POS_W-1:0] position;
	logic out_valid;
	logic out_ready;
	logic [STATUS_W-1:0] status;
	logic placed_before_end;
	logic [STAMP_W-1:0] removed_stamp;
	logic [COUNT_W-1:0] entry_count;

	logic steady;
	int errors, waiting, stored;
	int inserts, removes, full_refusals, range_refusals, peak_fill;
	int idle_cycles;
	int insert_bias [6] = '{70, 30, 50, 85, 15, 50};

	sorted_timestamp_list u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.stamp(stamp),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.placed_before_end(placed_before_end),
		.removed_stamp(removed_stamp),
		.entry_count(entry_count)
	);

	sorted_timestamp_list_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.stamp(stamp),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.placed_before_end(placed_before_end),
		.removed_stamp(removed_stamp),
		.entry_count(entry_count),
		.errors(errors),
		.waiting(waiting),
		.stored(stored),
		.inserts(inserts),
		.removes(removes),
		.full_refusals(full_refusals),
		.range_refusals(range_refusals),
		.peak_fill(peak_fill)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [STAMP_W-1:0] random_stamp();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return raw[STAMP_W-1:0];
			1: return STAMP_W'($urandom_range(0, 7));
			2: return STAMP_TOP - STAMP_W'($urandom_range(0, 3));
			default: return raw[STAMP_W-1:0] >> $urandom_range(0, STAMP_W - 1);
		endcase
	endfunction

	task automatic send_word(input logic op, input logic [STAMP_W-1:0] st,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		stamp <= st;
		position <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// hold the input off until every result word is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	// result side pacing
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[sorted_timestamp_list] ERROR");
		$finish;
	end

	initial begin
		logic op;
		logic [POS_W-1:0] pos;
		int k;
		int phase;
		steady = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_INSERT;
		stamp <= '0;
		position <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, then fill to the brim
		send_word(OP_REMOVE, '0, '0);
		send_word(OP_REMOVE, STAMP_TOP, '1);
		send_word(OP_INSERT, '0, '0);
		send_word(OP_INSERT, STAMP_TOP, '0);
		send_word(OP_INSERT, STAMP_TOP, '0);
		send_word(OP_INSERT, '0, '0);
		send_word(OP_INSERT, 63'h2AAA_AAAA_AAAA_AAAA, '0);
		send_word(OP_INSERT, 63'h5555_5555_5555_5555, '1);
		for (k = 0; k < 10; k++)
			send_word(OP_INSERT, random_stamp(), POS_W'($urandom_range(0, 15)));
		send_word(OP_INSERT, STAMP_TOP, '1);
		// last entry, past count, head, middle
		send_word(OP_REMOVE, '0, 4'd15);
		send_word(OP_REMOVE, '0, 4'd15);
		send_word(OP_REMOVE, STAMP_TOP, 4'd0);
		send_word(OP_REMOVE, '0, 4'd7);
		drain();

		for (phase = 0; phase < 6; phase++) begin
			steady = (phase == 2 || phase == 5);
			for (k = 0; k < PHASE_WORDS; k++) begin
				op = ($urandom_range(0, 99) < insert_bias[phase]) ? OP_INSERT : OP_REMOVE;
				if (stored == 0 || $urandom_range(0, 4) == 0)
					pos = POS_W'($urandom_range(0, 15));
				else
					pos = POS_W'($urandom_range(0, stored - 1));
				send_word(op, random_stamp(), pos);
			end
			drain();
		end

		steady = 1'b0;
		repeat (4) @(posedge clk);
		$display("covered %0d inserts (%0d refused as full) and %0d removes (%0d past count)",
			inserts, full_refusals, removes, range_refusals);
		$display("list held up to %0d entries, %0d mismatches", peak_fill, errors);
		if (errors == 0 && waiting == 0)
			$display("[sorted_timestamp_list] OK");
		else
			$display("[sorted_timestamp_list] ERROR");
		$finish;
	end

endmodule

/* files.f */
hdl/stl_pkg.sv
hdl/stl_cell.sv
hdl/sorted_timestamp_list.sv
dv/sorted_timestamp_list_check.sv
dv/sorted_timestamp_list_test.sv
